@@ src/trr_pkg.sv @@
// ----------------------------------------------------------------------------
// trr_pkg: shared types and constants for the token round-robin router
// Sizes, action and register codes, cell and payload structs, state encoding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package trr_pkg;

   localparam int RECEIVERS  = 8;
   localparam int TOKEN_BITS = 8;
   localparam int RANK_W     = $clog2(RECEIVERS);
   localparam int CNT_W      = $clog2(RECEIVERS + 1);
   localparam int SEQ_W      = 48;

   localparam logic [1:0] ACT_TOKEN = 2'd0;
   localparam logic [1:0] ACT_TURN  = 2'd1;
   localparam logic [1:0] ACT_ROUTE = 2'd2;

   localparam logic CSR_MIN_PART  = 1'b0;
   localparam logic CSR_RCV_COUNT = 1'b1;

   typedef struct packed {
      logic [TOKEN_BITS-1:0] count;
      logic                  member;
   } cell_type;

   typedef struct packed {
      logic [1:0]       action;
      logic [5:0]       token_rank;
      logic [SEQ_W-1:0] request_seq;
   } req_type;

   typedef struct packed {
      logic             entry_valid;
      logic [SEQ_W-1:0] entry_seq;
      logic [5:0]       dest_rank;
      logic             last_of_run;
      logic             table_done;
      logic             token_dropped;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_COUNT = 3'b010,
      S_WORK  = 3'b100
   } state_type;

   // true when fewer holders than the configured minimum (minimum floors at 1)
   function automatic logic below_min(input logic [CNT_W-1:0] holders,
                                      input logic signed [7:0] mp,
                                      input logic [6:0] rc);
      logic signed [8:0] m;
      logic signed [8:0] h;
      begin
         h = $signed(9'(holders));
         if (mp > 8'sd0) begin
            m = $signed({mp[7], mp});
         end else begin
            m = $signed({2'b00, rc}) + $signed({mp[7], mp});
         end
         below_min = (holders == '0) || (h < m);
      end
   endfunction

endpackage

@@ src/trr_cell.sv @@
// ----------------------------------------------------------------------------
// trr_cell: one receiver slot of the token ring
// Holds a saturating token count and a round-member bit; shifts to neighbor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trr_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift,
   input  logic              credit,
   input  trr_pkg::cell_type cell_in,
   output trr_pkg::cell_type cell_out,
   output logic              sat
);

   trr_pkg::cell_type cell_ff;
   trr_pkg::cell_type cell_in_nxt;

   assign sat = (cell_ff.count == '1);

   always_comb begin
      cell_in_nxt = cell_ff;
      if (shift) begin
         cell_in_nxt = cell_in;
      end else if (credit && !sat) begin
         cell_in_nxt.count = cell_ff.count + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else begin
         cell_ff <= cell_in_nxt;
      end
   end

   assign cell_out = cell_ff;

endmodule

@@ src/token_round_robin_router_top.sv @@
// ----------------------------------------------------------------------------
// token_round_robin_router_top: credit-based round-robin router
// Token ring of receiver cells with a sequencer at the head position.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : valid/ready input; one transaction is a token credit, a table
//            turn or a route request.
//   rsp_*  : valid/ready results, one per cycle at most, through an output
//            register. A turn yields one per holder (one if short), else one.
//   csr_*  : write-only registers, min_participants (0), receiver_count (1).
// Sequencing: the receiver cells form a ring that rotates through the head
//   slot, one rank per cycle unless stalled, and comes back home.
//   Token credit / unused code: result written to the output register on accept.
//   Route from an open round, or turn/route short of holders: one rotation.
//   Turn, or route that forms a new round: a counting rotation, then a
//   working rotation.
//   One transaction is in work at a time; a new one is taken once the ring
//   is home and the output register is free.
// Stall: while the output register is full and rsp_ready is low, counting
//   pauses and the working rotation holds at the next slot that must emit.
// Reset: tokens and round cleared, next sequence 1, min_participants 0,
//   receiver_count 8; req_ready rises as soon as reset drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module token_round_robin_router_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  trr_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output trr_pkg::rsp_type rsp_payload,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [7:0]       csr_wdata
);

   localparam int R = trr_pkg::RECEIVERS;

   trr_pkg::cell_type cell_q [R];
   trr_pkg::cell_type cell_d [R];
   logic [R-1:0]      sat_vec;
   logic [R-1:0]      rank_hit;
   logic [R-1:0]      credit_vec;

   logic signed [7:0] min_part_ff;
   logic [6:0]        rcv_count_ff;

   trr_pkg::state_type           state_ff, state_in;
   logic [trr_pkg::RANK_W-1:0]   step_ff, step_in;
   logic                         turn_ff, turn_in;
   logic                         form_ff, form_in;
   logic                         pop_ff, pop_in;
   logic                         done_ff, done_in;
   logic [trr_pkg::CNT_W-1:0]    hold_ff, hold_in;
   logic [trr_pkg::CNT_W-1:0]    after_ff, after_in;
   logic [trr_pkg::CNT_W-1:0]    left_ff, left_in;
   logic [trr_pkg::CNT_W-1:0]    mcnt_ff, mcnt_in;
   logic [trr_pkg::SEQ_W-1:0]    seq_ff, seq_in;
   logic [trr_pkg::SEQ_W-1:0]    rseq_ff, rseq_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   trr_pkg::rsp_type             rsp_ff, rsp_in;

   trr_pkg::cell_type            head, head_new;
   logic                         out_free, req_fire, last_step, head_busy;
   logic                         want, emit, shift, credit_go, tok_ok;
   trr_pkg::rsp_type             emit_data;
   logic [trr_pkg::CNT_W-1:0]    hold_fin, after_fin;

   // ---- ring of cells ----
   genvar i;
   generate
      for (i = 0; i < R; i++) begin : g_cell
         assign rank_hit[i]   = (req_payload.token_rank == 6'(i));
         assign credit_vec[i] = credit_go && rank_hit[i];
         if (i == R - 1) begin : g_tail
            assign cell_d[i] = head_new;
         end else begin : g_body
            assign cell_d[i] = cell_q[i+1];
         end
         trr_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift    (shift),
            .credit   (credit_vec[i]),
            .cell_in  (cell_d[i]),
            .cell_out (cell_q[i]),
            .sat      (sat_vec[i])
         );
      end
   endgenerate

   assign head      = cell_q[0];
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !reset && (state_ff == trr_pkg::S_IDLE) && out_free;
   assign req_fire  = req_valid && req_ready;
   assign last_step = (step_ff == trr_pkg::RANK_W'(R - 1));
   assign head_busy = (head.count != '0);
   assign hold_fin  = hold_ff + trr_pkg::CNT_W'(head_busy);
   assign after_fin = after_ff + trr_pkg::CNT_W'(head.count > trr_pkg::TOKEN_BITS'(1));
   assign tok_ok    = |(rank_hit & ~sat_vec);

   // ---- sequencer ----
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      turn_in   = turn_ff;
      form_in   = form_ff;
      pop_in    = pop_ff;
      done_in   = done_ff;
      hold_in   = hold_ff;
      after_in  = after_ff;
      left_in   = left_ff;
      mcnt_in   = mcnt_ff;
      seq_in    = seq_ff;
      rseq_in   = rseq_ff;
      head_new  = head;
      want      = 1'b0;
      emit      = 1'b0;
      shift     = 1'b0;
      credit_go = 1'b0;
      emit_data = '0;

      unique case (state_ff)
         trr_pkg::S_IDLE: begin
            if (req_fire) begin
               unique case (req_payload.action)
                  trr_pkg::ACT_TOKEN: begin
                     credit_go               = 1'b1;
                     emit                    = 1'b1;
                     emit_data.last_of_run   = 1'b1;
                     emit_data.token_dropped = !tok_ok;
                  end
                  trr_pkg::ACT_TURN: begin
                     turn_in  = 1'b1;
                     hold_in  = '0;
                     after_in = '0;
                     state_in = trr_pkg::S_COUNT;
                  end
                  trr_pkg::ACT_ROUTE: begin
                     turn_in = 1'b0;
                     rseq_in = req_payload.request_seq;
                     if (mcnt_ff != '0) begin
                        form_in  = 1'b0;
                        pop_in   = 1'b1;
                        mcnt_in  = mcnt_ff - 1'b1;
                        state_in = trr_pkg::S_WORK;
                     end else begin
                        hold_in  = '0;
                        after_in = '0;
                        state_in = trr_pkg::S_COUNT;
                     end
                  end
                  default: begin
                     emit                  = 1'b1;
                     emit_data.last_of_run = 1'b1;
                  end
               endcase
            end
         end

         trr_pkg::S_COUNT: begin
            // counting rotation: head passes through unchanged
            if (out_free) begin
               shift    = 1'b1;
               step_in  = step_ff + 1'b1;
               hold_in  = hold_fin;
               after_in = after_fin;
               if (last_step) begin
                  step_in = '0;
                  if (trr_pkg::below_min(hold_fin, min_part_ff, rcv_count_ff)) begin
                     emit                  = 1'b1;
                     emit_data.last_of_run = 1'b1;
                     emit_data.table_done  = turn_ff;
                     state_in              = trr_pkg::S_IDLE;
                  end else begin
                     done_in  = trr_pkg::below_min(after_fin, min_part_ff, rcv_count_ff);
                     left_in  = hold_fin;
                     form_in  = 1'b1;
                     pop_in   = 1'b1;
                     state_in = trr_pkg::S_WORK;
                     if (!turn_ff) begin
                        mcnt_in = hold_fin - 1'b1;
                     end
                  end
               end
            end
         end

         trr_pkg::S_WORK: begin
            if (turn_ff) begin
               if (head_busy) begin
                  want           = 1'b1;
                  head_new.count = head.count - 1'b1;
               end
            end else if (form_ff) begin
               // new round: every holder pays a token, first one is popped
               if (head_busy) begin
                  head_new.count = head.count - 1'b1;
                  if (pop_ff) begin
                     want = 1'b1;
                  end else begin
                     head_new.member = 1'b1;
                  end
               end
            end else if (head.member && pop_ff) begin
               want            = 1'b1;
               head_new.member = 1'b0;
            end

            if (!want || out_free) begin
               shift   = 1'b1;
               step_in = step_ff + 1'b1;
               if (want) begin
                  emit                  = 1'b1;
                  emit_data.entry_valid = 1'b1;
                  emit_data.dest_rank   = 6'(step_ff);
                  if (turn_ff) begin
                     emit_data.entry_seq   = seq_ff;
                     emit_data.last_of_run = (left_ff == trr_pkg::CNT_W'(1));
                     emit_data.table_done  = done_ff;
                     seq_in                = seq_ff + 1'b1;
                     left_in               = left_ff - 1'b1;
                  end else begin
                     emit_data.entry_seq   = rseq_ff;
                     emit_data.last_of_run = 1'b1;
                     pop_in                = 1'b0;
                  end
               end
               if (last_step) begin
                  step_in  = '0;
                  state_in = trr_pkg::S_IDLE;
               end
            end
         end

         default: begin
            state_in = trr_pkg::S_IDLE;
         end
      endcase
   end

   // ---- output register ----
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_in       = emit_data;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= trr_pkg::S_IDLE;
         step_ff      <= '0;
         pop_ff       <= 1'b0;
         left_ff      <= '0;
         mcnt_ff      <= '0;
         seq_ff       <= trr_pkg::SEQ_W'(1);
         rsp_valid_ff <= 1'b0;
         min_part_ff  <= '0;
         rcv_count_ff <= 7'd8;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         pop_ff       <= pop_in;
         left_ff      <= left_in;
         mcnt_ff      <= mcnt_in;
         seq_ff       <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               trr_pkg::CSR_MIN_PART:  min_part_ff  <= $signed(csr_wdata);
               trr_pkg::CSR_RCV_COUNT: rcv_count_ff <= csr_wdata[6:0];
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      turn_ff  <= turn_in;
      form_ff  <= form_in;
      done_ff  <= done_in;
      hold_ff  <= hold_in;
      after_ff <= after_in;
      rseq_ff  <= rseq_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // ---- assertions ----
   // ring must be at home whenever a new transaction can start
   a_home_when_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == trr_pkg::S_IDLE) |-> (step_ff == '0))
      else $error("ring not at home position while idle");

   // a transaction is only taken when its result has room
   a_accept_room: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> (!rsp_valid_ff || rsp_ready))
      else $error("transaction accepted with output register blocked");

   // a turn never emits more entries than holders counted
   a_turn_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == trr_pkg::S_WORK && turn_ff && head_busy) |-> (left_ff != '0))
      else $error("turn emitting beyond counted holders");

endmodule
